[design/sprite_video_register_file_macros.svh]
// assertion macros shared by the sprite video register file checkers
// depends on: a clk and rst_n in the scope of each use
`ifndef SPRITE_VIDEO_REGISTER_FILE_MACROS_SVH
`define SPRITE_VIDEO_REGISTER_FILE_MACROS_SVH

// antecedent and consequent in the same cycle
`define SVRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent ends
`define SVRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/svrf_pkg.sv]
// shared types and constants of the sprite video register file
// no dependencies
package svrf_pkg;

    // number of sprites with live position and colour registers
    localparam int SPRITE_COUNT = 8;
    localparam int SPRITE_SLOTS = 8;

    // operation codes
    typedef enum logic [2:0] {
        OP_READ   = 3'd0,
        OP_WRITE  = 3'd1,
        OP_PEEK   = 3'd2,
        OP_PEN    = 3'd3,
        OP_EVENT  = 3'd4,
        OP_FRAME  = 3'd5
    } svrf_op_t;

    // register offsets
    localparam logic [5:0] REG_SPRITE_END   = 6'h10;
    localparam logic [5:0] REG_X_HIGH       = 6'h10;
    localparam logic [5:0] REG_CONTROL_ONE  = 6'h11;
    localparam logic [5:0] REG_RASTER       = 6'h12;
    localparam logic [5:0] REG_PEN_X        = 6'h13;
    localparam logic [5:0] REG_PEN_Y        = 6'h14;
    localparam logic [5:0] REG_ENABLE       = 6'h15;
    localparam logic [5:0] REG_CONTROL_TWO  = 6'h16;
    localparam logic [5:0] REG_EXPAND_Y     = 6'h17;
    localparam logic [5:0] REG_MEMORY       = 6'h18;
    localparam logic [5:0] REG_IRQ_STATUS   = 6'h19;
    localparam logic [5:0] REG_IRQ_MASK     = 6'h1A;
    localparam logic [5:0] REG_PRIORITY     = 6'h1B;
    localparam logic [5:0] REG_MULTICOLOR   = 6'h1C;
    localparam logic [5:0] REG_EXPAND_X     = 6'h1D;
    localparam logic [5:0] REG_SPRITE_HIT   = 6'h1E;
    localparam logic [5:0] REG_DATA_HIT     = 6'h1F;
    localparam logic [5:0] REG_BORDER       = 6'h20;
    localparam logic [5:0] REG_BACK_FIRST   = 6'h21;
    localparam logic [5:0] REG_BACK_LAST    = 6'h24;
    localparam logic [5:0] REG_SHARED_0     = 6'h25;
    localparam logic [5:0] REG_SHARED_1     = 6'h26;
    localparam logic [5:0] REG_COLOUR_FIRST = 6'h27;
    localparam logic [5:0] REG_COLOUR_LAST  = 6'h2E;

    // padding and masks
    localparam logic [7:0] PAD_HIGH_NIBBLE  = 8'hF0;
    localparam logic [7:0] PAD_IRQ_STATUS   = 8'h70;
    localparam logic [7:0] MEMORY_WR_MASK   = 8'hFE;
    localparam logic [7:0] MEMORY_RD_SET    = 8'h01;
    localparam logic [7:0] BUS_KEEP_MASK    = 8'hE0;
    localparam logic [7:0] UNMAPPED_PEEK    = 8'hFF;
    localparam logic [7:0] BUS_RESET        = 8'hFF;
    localparam logic [3:0] IRQ_PEN_BIT      = 4'h8;

    // request transaction
    typedef struct packed {
        logic [2:0] opcode;
        logic [5:0] reg_offset;
        logic [7:0] write_data;
        logic [8:0] raster_line;
        logic [8:0] beam_dot;
        logic [7:0] sprite_hit_bits;
        logic [7:0] background_hit_bits;
        logic [3:0] irq_source_bits;
    } svrf_req_t;

    // response transaction
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic [7:0] expand_cleared;
    } svrf_rsp_t;

endpackage

[design/svrf_core.sv]
// register state and single-pass decode of one request transaction
// depends on: svrf_pkg
module svrf_core
    import svrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  svrf_req_t item,
    output svrf_rsp_t result
);

    logic [7:0] sprite_x_low_reg [SPRITE_SLOTS];
    logic [7:0] sprite_x_low_next [SPRITE_SLOTS];
    logic [7:0] sprite_y_pos_reg [SPRITE_SLOTS];
    logic [7:0] sprite_y_pos_next [SPRITE_SLOTS];
    logic [3:0] sprite_colours_reg [SPRITE_SLOTS];
    logic [3:0] sprite_colours_next [SPRITE_SLOTS];
    logic [3:0] back_colours_reg [4];
    logic [3:0] back_colours_next [4];
    logic [3:0] shared_colours_reg [2];
    logic [3:0] shared_colours_next [2];
    logic [7:0] sprite_x_high_reg, sprite_x_high_next;
    logic [6:0] control_one_reg, control_one_next;
    logic [7:0] control_two_reg, control_two_next;
    logic [8:0] raster_compare_reg, raster_compare_next;
    logic [7:0] sprite_enable_reg, sprite_enable_next;
    logic [7:0] expand_y_reg, expand_y_next;
    logic [7:0] expand_x_reg, expand_x_next;
    logic [7:0] memory_setup_reg, memory_setup_next;
    logic [3:0] irq_pending_reg, irq_pending_next;
    logic [3:0] irq_mask_reg, irq_mask_next;
    logic [7:0] priority_bits_reg, priority_bits_next;
    logic [7:0] multicolor_bits_reg, multicolor_bits_next;
    logic [7:0] sprite_collide_reg, sprite_collide_next;
    logic [7:0] data_collide_reg, data_collide_next;
    logic [3:0] border_colour_reg, border_colour_next;
    logic [7:0] pen_x_reg, pen_x_next;
    logic [7:0] pen_y_reg, pen_y_next;
    logic       pen_done_reg, pen_done_next;
    logic [7:0] bus_byte_reg, bus_byte_next;

    svrf_op_t   op;
    logic [5:0] off;
    logic [7:0] wd;
    logic [2:0] pos_idx;
    logic [2:0] col_idx;
    logic [1:0] back_idx;
    logic       pos_ok;
    logic       col_ok;
    logic       in_back;
    logic       in_colour;
    logic       irq_now;
    logic [7:0] view_data;
    logic       view_mapped;
    logic [7:0] peek_data;
    logic [7:0] read_data;
    logic [7:0] expand_cleared;

    // field decode
    assign op        = svrf_op_t'(item.opcode);
    assign off       = item.reg_offset;
    assign wd        = item.write_data;
    assign pos_idx   = off[3:1];
    assign col_idx   = 3'(off - REG_COLOUR_FIRST);
    assign back_idx  = 2'(off - REG_BACK_FIRST);
    assign pos_ok    = (int'(pos_idx) < SPRITE_COUNT);
    assign col_ok    = (int'(col_idx) < SPRITE_COUNT);
    assign in_back   = (off >= REG_BACK_FIRST) && (off <= REG_BACK_LAST);
    assign in_colour = (off >= REG_COLOUR_FIRST) && (off <= REG_COLOUR_LAST);
    assign irq_now   = |(irq_pending_reg & irq_mask_reg);

    // value a bus read shows, before the unmapped fallback
    always_comb
    begin
        view_mapped = 1'b1;
        view_data   = 8'h00;
        if (off < REG_SPRITE_END)
        begin
            if (pos_ok)
            begin
                view_data = off[0] ? sprite_y_pos_reg[pos_idx] : sprite_x_low_reg[pos_idx];
            end
            else
            begin
                view_mapped = 1'b0;
            end
        end
        else if (in_back)
        begin
            view_data = PAD_HIGH_NIBBLE | {4'h0, back_colours_reg[back_idx]};
        end
        else if (in_colour)
        begin
            if (col_ok)
            begin
                view_data = PAD_HIGH_NIBBLE | {4'h0, sprite_colours_reg[col_idx]};
            end
            else
            begin
                view_mapped = 1'b0;
            end
        end
        else
        begin
            unique case (off)
                REG_X_HIGH:      view_data = sprite_x_high_reg;
                REG_CONTROL_ONE: view_data = {item.raster_line[8], control_one_reg};
                REG_RASTER:      view_data = item.raster_line[7:0];
                REG_PEN_X:       view_data = pen_x_reg;
                REG_PEN_Y:       view_data = pen_y_reg;
                REG_ENABLE:      view_data = sprite_enable_reg;
                REG_CONTROL_TWO: view_data = (control_two_reg & ~BUS_KEEP_MASK)
                                             | (bus_byte_reg & BUS_KEEP_MASK);
                REG_EXPAND_Y:    view_data = expand_y_reg;
                REG_MEMORY:      view_data = memory_setup_reg | MEMORY_RD_SET;
                REG_IRQ_STATUS:  view_data = {irq_now, 3'b000, irq_pending_reg}
                                             | PAD_IRQ_STATUS;
                REG_IRQ_MASK:    view_data = PAD_HIGH_NIBBLE | {4'h0, irq_mask_reg};
                REG_PRIORITY:    view_data = priority_bits_reg;
                REG_MULTICOLOR:  view_data = multicolor_bits_reg;
                REG_EXPAND_X:    view_data = expand_x_reg;
                REG_SPRITE_HIT:  view_data = sprite_collide_reg;
                REG_DATA_HIT:    view_data = data_collide_reg;
                REG_BORDER:      view_data = PAD_HIGH_NIBBLE | {4'h0, border_colour_reg};
                REG_SHARED_0:    view_data = PAD_HIGH_NIBBLE | {4'h0, shared_colours_reg[0]};
                REG_SHARED_1:    view_data = PAD_HIGH_NIBBLE | {4'h0, shared_colours_reg[1]};
                default:         view_mapped = 1'b0;
            endcase
        end
    end

    // peek shows raw storage for a few offsets, otherwise the read view, or all ones if unmapped
    always_comb
    begin
        unique case (off)
            REG_CONTROL_TWO: peek_data = control_two_reg;
            REG_MEMORY:      peek_data = memory_setup_reg;
            REG_BORDER:      peek_data = {4'h0, border_colour_reg};
            REG_BACK_FIRST:  peek_data = {4'h0, back_colours_reg[0]};
            REG_SHARED_0:    peek_data = {4'h0, shared_colours_reg[0]};
            REG_SHARED_1:    peek_data = {4'h0, shared_colours_reg[1]};
            default:         peek_data = view_mapped ? view_data : UNMAPPED_PEEK;
        endcase
    end

    // next state and response fields
    always_comb
    begin
        sprite_x_low_next    = sprite_x_low_reg;
        sprite_y_pos_next    = sprite_y_pos_reg;
        sprite_colours_next  = sprite_colours_reg;
        back_colours_next    = back_colours_reg;
        shared_colours_next  = shared_colours_reg;
        sprite_x_high_next   = sprite_x_high_reg;
        control_one_next     = control_one_reg;
        control_two_next     = control_two_reg;
        raster_compare_next  = raster_compare_reg;
        sprite_enable_next   = sprite_enable_reg;
        expand_y_next        = expand_y_reg;
        expand_x_next        = expand_x_reg;
        memory_setup_next    = memory_setup_reg;
        irq_pending_next     = irq_pending_reg;
        irq_mask_next        = irq_mask_reg;
        priority_bits_next   = priority_bits_reg;
        multicolor_bits_next = multicolor_bits_reg;
        sprite_collide_next  = sprite_collide_reg;
        data_collide_next    = data_collide_reg;
        border_colour_next   = border_colour_reg;
        pen_x_next           = pen_x_reg;
        pen_y_next           = pen_y_reg;
        pen_done_next        = pen_done_reg;
        bus_byte_next        = bus_byte_reg;
        read_data            = 8'h00;
        expand_cleared       = 8'h00;

        unique case (op)
            OP_READ:
            begin
                if (view_mapped)
                begin
                    read_data     = view_data;
                    bus_byte_next = view_data;
                    // collision registers clear on read
                    if (off == REG_SPRITE_HIT)
                    begin
                        sprite_collide_next = 8'h00;
                    end
                    if (off == REG_DATA_HIT)
                    begin
                        data_collide_next = 8'h00;
                    end
                end
                else
                begin
                    read_data = bus_byte_reg;
                end
            end
            OP_PEEK:
            begin
                read_data = peek_data;
            end
            OP_WRITE:
            begin
                if (off < REG_SPRITE_END)
                begin
                    if (pos_ok)
                    begin
                        if (off[0])
                        begin
                            sprite_y_pos_next[pos_idx] = wd;
                        end
                        else
                        begin
                            sprite_x_low_next[pos_idx] = wd;
                        end
                    end
                end
                else if (in_back)
                begin
                    back_colours_next[back_idx] = wd[3:0];
                end
                else if (in_colour)
                begin
                    if (col_ok)
                    begin
                        sprite_colours_next[col_idx] = wd[3:0];
                    end
                end
                else
                begin
                    unique case (off)
                        REG_X_HIGH:      sprite_x_high_next = wd;
                        REG_CONTROL_ONE:
                        begin
                            control_one_next       = wd[6:0];
                            raster_compare_next[8] = wd[7];
                        end
                        REG_RASTER:      raster_compare_next[7:0] = wd;
                        REG_ENABLE:      sprite_enable_next = wd;
                        REG_CONTROL_TWO: control_two_next = wd;
                        REG_EXPAND_Y:
                        begin
                            expand_cleared = expand_y_reg & ~wd;
                            expand_y_next  = wd;
                        end
                        REG_MEMORY:      memory_setup_next = wd & MEMORY_WR_MASK;
                        REG_IRQ_STATUS:  irq_pending_next = irq_pending_reg & ~wd[3:0];
                        REG_IRQ_MASK:    irq_mask_next = wd[3:0];
                        REG_PRIORITY:    priority_bits_next = wd;
                        REG_MULTICOLOR:  multicolor_bits_next = wd;
                        REG_EXPAND_X:    expand_x_next = wd;
                        REG_BORDER:      border_colour_next = wd[3:0];
                        REG_SHARED_0:    shared_colours_next[0] = wd[3:0];
                        REG_SHARED_1:    shared_colours_next[1] = wd[3:0];
                        default:         ;
                    endcase
                end
            end
            OP_PEN:
            begin
                // only the first strobe of a frame latches
                if (!pen_done_reg)
                begin
                    pen_x_next       = item.beam_dot[8:1];
                    pen_y_next       = item.raster_line[7:0];
                    pen_done_next    = 1'b1;
                    irq_pending_next = irq_pending_reg | IRQ_PEN_BIT;
                end
            end
            OP_EVENT:
            begin
                sprite_collide_next = sprite_collide_reg | item.sprite_hit_bits;
                data_collide_next   = data_collide_reg | item.background_hit_bits;
                irq_pending_next    = irq_pending_reg | item.irq_source_bits;
            end
            OP_FRAME:
            begin
                pen_done_next = 1'b0;
            end
            default: ;
        endcase
    end

    assign result.read_data      = read_data;
    assign result.irq_out        = |(irq_pending_next & irq_mask_next);
    assign result.expand_cleared = expand_cleared;

    // state registers, updated once per processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SPRITE_SLOTS; i++)
            begin
                sprite_x_low_reg[i]   <= 8'h00;
                sprite_y_pos_reg[i]   <= 8'h00;
                sprite_colours_reg[i] <= 4'h0;
            end
            for (int i = 0; i < 4; i++)
            begin
                back_colours_reg[i] <= 4'h0;
            end
            for (int i = 0; i < 2; i++)
            begin
                shared_colours_reg[i] <= 4'h0;
            end
            sprite_x_high_reg   <= 8'h00;
            control_one_reg     <= 7'h00;
            control_two_reg     <= 8'h00;
            raster_compare_reg  <= 9'h000;
            sprite_enable_reg   <= 8'h00;
            expand_y_reg        <= 8'h00;
            expand_x_reg        <= 8'h00;
            memory_setup_reg    <= 8'h00;
            irq_pending_reg     <= 4'h0;
            irq_mask_reg        <= 4'h0;
            priority_bits_reg   <= 8'h00;
            multicolor_bits_reg <= 8'h00;
            sprite_collide_reg  <= 8'h00;
            data_collide_reg    <= 8'h00;
            border_colour_reg   <= 4'h0;
            pen_x_reg           <= 8'h00;
            pen_y_reg           <= 8'h00;
            pen_done_reg        <= 1'b0;
            bus_byte_reg        <= BUS_RESET;
        end
        else if (fire)
        begin
            sprite_x_low_reg    <= sprite_x_low_next;
            sprite_y_pos_reg    <= sprite_y_pos_next;
            sprite_colours_reg  <= sprite_colours_next;
            back_colours_reg    <= back_colours_next;
            shared_colours_reg  <= shared_colours_next;
            sprite_x_high_reg   <= sprite_x_high_next;
            control_one_reg     <= control_one_next;
            control_two_reg     <= control_two_next;
            raster_compare_reg  <= raster_compare_next;
            sprite_enable_reg   <= sprite_enable_next;
            expand_y_reg        <= expand_y_next;
            expand_x_reg        <= expand_x_next;
            memory_setup_reg    <= memory_setup_next;
            irq_pending_reg     <= irq_pending_next;
            irq_mask_reg        <= irq_mask_next;
            priority_bits_reg   <= priority_bits_next;
            multicolor_bits_reg <= multicolor_bits_next;
            sprite_collide_reg  <= sprite_collide_next;
            data_collide_reg    <= data_collide_next;
            border_colour_reg   <= border_colour_next;
            pen_x_reg           <= pen_x_next;
            pen_y_reg           <= pen_y_next;
            pen_done_reg        <= pen_done_next;
            bus_byte_reg        <= bus_byte_next;
        end
    end

endmodule

[design/sprite_video_register_file.sv]
// Sprite video register file: 47 byte-wide controller registers behind one
// request channel and one response channel, both valid/ready.
// Each request transaction (read, write, peek, light pen strobe, video event
// or frame start) yields exactly one response transaction carrying read data,
// the interrupt line after the operation and the expand-y bits a write cleared.
// A request is held in an input register; it is decoded against the register
// state in one pass and its response lands in an output register once that
// register is free or being emptied.
// Throughput is one transaction per cycle: req_ready stays high as long as the
// output register drains, set by the single decode stage between the two.
// When the receiver stalls (rsp_valid high, rsp_ready low) the response holds;
// one more request can still be taken into the input register, after which
// req_ready drops until the response is taken.
// Reset empties both pipeline registers and returns all registers to zero,
// except the last bus byte, which resets to all ones. No clearing pass.
// depends on: svrf_pkg, svrf_core
module sprite_video_register_file
    import svrf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  svrf_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output svrf_rsp_t rsp
);

    logic      in_valid_reg;
    svrf_req_t in_item_reg;
    logic      out_valid_reg;
    svrf_rsp_t out_item_reg;
    logic      fire;
    svrf_rsp_t result;

    // process the held request when the output register is free or being emptied
    assign fire      = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || fire;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    svrf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_item_reg <= req;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_item_reg <= result;
        end
    end

endmodule

[design/svrf_checker.sv]
// port-level checks for the sprite video register file, bound to the top level
// depends on: svrf_pkg, sprite_video_register_file_macros.svh
`include "sprite_video_register_file_macros.svh"

module svrf_checker
    import svrf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input svrf_req_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input svrf_rsp_t rsp
);

    logic req_take;
    logic rsp_free;
    logic req_no_data;
    logic req_no_clear;

    assign req_take     = req_valid && req_ready;
    assign rsp_free     = !rsp_valid || rsp_ready;
    assign req_no_data  = (req.opcode != OP_READ) && (req.opcode != OP_PEEK);
    assign req_no_clear = (req.opcode != OP_WRITE) || (req.reg_offset != REG_EXPAND_Y);

    // stalled response transaction holds
    `SVRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")

    // an accepted request followed by a free output stage yields a valid response
    `SVRF_ASSERT_NEXT(a_latency, req_take ##1 rsp_free, rsp_valid, "response missing after two cycles")

    // only reads and peeks return data
    `SVRF_ASSERT_NEXT(a_no_data, (req_take && req_no_data) ##1 rsp_free, rsp.read_data == 8'h00, "read data on a non-read operation")

    // only a write to expand-y reports cleared bits
    `SVRF_ASSERT_NEXT(a_no_clear, (req_take && req_no_clear) ##1 rsp_free, rsp.expand_cleared == 8'h00, "expand bits reported without an expand write")

endmodule

bind sprite_video_register_file svrf_checker u_svrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[verif/testbench.sv]
`timescale 1ns / 100ps
// self-checking testbench for the sprite video register file: directed table, then random traffic
// depends on: svrf_pkg, sprite_video_register_file
module testbench;
    import svrf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 250;

    // opcodes the block treats as no operation
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    // offsets outside the register map
    localparam logic [5:0] REG_UNMAPPED_FIRST = 6'h2F;
    localparam logic [5:0] REG_OFFSET_TOP     = 6'h3F;

    typedef struct packed {
        svrf_req_t item;
        logic      fixed;
        svrf_rsp_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    svrf_req_t request = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    svrf_rsp_t response;

    svrf_rsp_t expected_q[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;
    int        phase_send_gap[5] = '{0, 69, 0, 30, 0};
    int        phase_recv_stall[5] = '{0, 0, 69, 30, 0};

    // shadow copy of the register state
    logic [7:0] pos_x_lo [SPRITE_SLOTS];
    logic [7:0] pos_y [SPRITE_SLOTS];
    logic [3:0] colour_of [SPRITE_SLOTS];
    logic [3:0] back_of [4];
    logic [3:0] shared_of [2];
    logic [7:0] x_msbs;
    logic [6:0] ctrl_a;
    logic [7:0] ctrl_b;
    logic [8:0] line_cmp;
    logic [7:0] enables;
    logic [7:0] stretch_y;
    logic [7:0] stretch_x;
    logic [7:0] mem_ptrs;
    logic [3:0] irq_pend;
    logic [3:0] irq_en;
    logic [7:0] prio;
    logic [7:0] mcolor;
    logic [7:0] spr_hits;
    logic [7:0] bg_hits;
    logic [3:0] border;
    logic [7:0] pen_col;
    logic [7:0] pen_row;
    logic       pen_latched;
    logic [7:0] last_bus;

    sprite_video_register_file dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (request),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (response)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic logic irq_active();
        return |(irq_pend & irq_en);
    endfunction

    // what a bus read shows at an offset, before any read-clear
    function automatic logic [7:0] register_view(input logic [5:0] off, input logic [8:0] raster,
                                                 output logic hit);
        logic [5:0] idx;
        hit = 1'b1;
        if (off < REG_SPRITE_END)
        begin
            if (int'(off[3:1]) < SPRITE_COUNT)
                return off[0] ? pos_y[off[3:1]] : pos_x_lo[off[3:1]];
            hit = 1'b0;
            return 8'h00;
        end
        if (off >= REG_BACK_FIRST && off <= REG_BACK_LAST)
        begin
            idx = off - REG_BACK_FIRST;
            return PAD_HIGH_NIBBLE | {4'h0, back_of[idx[1:0]]};
        end
        if (off >= REG_COLOUR_FIRST && off <= REG_COLOUR_LAST)
        begin
            idx = off - REG_COLOUR_FIRST;
            if (int'(idx) < SPRITE_COUNT)
                return PAD_HIGH_NIBBLE | {4'h0, colour_of[idx[2:0]]};
            hit = 1'b0;
            return 8'h00;
        end
        case (off)
            REG_X_HIGH:      return x_msbs;
            REG_CONTROL_ONE: return {raster[8], ctrl_a};
            REG_RASTER:      return raster[7:0];
            REG_PEN_X:       return pen_col;
            REG_PEN_Y:       return pen_row;
            REG_ENABLE:      return enables;
            REG_CONTROL_TWO: return (ctrl_b & ~BUS_KEEP_MASK) | (last_bus & BUS_KEEP_MASK);
            REG_EXPAND_Y:    return stretch_y;
            REG_MEMORY:      return mem_ptrs | MEMORY_RD_SET;
            REG_IRQ_STATUS:  return {irq_active(), 7'h00} | PAD_IRQ_STATUS | {4'h0, irq_pend};
            REG_IRQ_MASK:    return PAD_HIGH_NIBBLE | {4'h0, irq_en};
            REG_PRIORITY:    return prio;
            REG_MULTICOLOR:  return mcolor;
            REG_EXPAND_X:    return stretch_x;
            REG_SPRITE_HIT:  return spr_hits;
            REG_DATA_HIT:    return bg_hits;
            REG_BORDER:      return PAD_HIGH_NIBBLE | {4'h0, border};
            REG_SHARED_0:    return PAD_HIGH_NIBBLE | {4'h0, shared_of[0]};
            REG_SHARED_1:    return PAD_HIGH_NIBBLE | {4'h0, shared_of[1]};
            default:         hit = 1'b0;
        endcase
        return 8'h00;
    endfunction

    // apply one request transaction to the shadow state, return its response
    function automatic svrf_rsp_t register_access(input svrf_req_t r);
        svrf_rsp_t  o;
        logic       hit;
        logic [7:0] v;
        logic [7:0] wd;
        logic [5:0] off;
        logic [5:0] idx;
        o = '0;
        off = r.reg_offset;
        wd = r.write_data;
        case (r.opcode)
            OP_READ:
            begin
                v = register_view(off, r.raster_line, hit);
                if (hit)
                begin
                    last_bus = v;
                    if (off == REG_SPRITE_HIT)
                        spr_hits = 8'h00;
                    if (off == REG_DATA_HIT)
                        bg_hits = 8'h00;
                    o.read_data = v;
                end
                else
                    o.read_data = last_bus;
            end
            OP_WRITE:
            begin
                if (off < REG_SPRITE_END)
                begin
                    if (int'(off[3:1]) < SPRITE_COUNT)
                    begin
                        if (off[0])
                            pos_y[off[3:1]] = wd;
                        else
                            pos_x_lo[off[3:1]] = wd;
                    end
                end
                else if (off >= REG_BACK_FIRST && off <= REG_BACK_LAST)
                begin
                    idx = off - REG_BACK_FIRST;
                    back_of[idx[1:0]] = wd[3:0];
                end
                else if (off >= REG_COLOUR_FIRST && off <= REG_COLOUR_LAST)
                begin
                    idx = off - REG_COLOUR_FIRST;
                    if (int'(idx) < SPRITE_COUNT)
                        colour_of[idx[2:0]] = wd[3:0];
                end
                else
                begin
                    case (off)
                        REG_X_HIGH:      x_msbs = wd;
                        REG_CONTROL_ONE:
                        begin
                            ctrl_a = wd[6:0];
                            line_cmp[8] = wd[7];
                        end
                        REG_RASTER:      line_cmp[7:0] = wd;
                        REG_ENABLE:      enables = wd;
                        REG_CONTROL_TWO: ctrl_b = wd;
                        REG_EXPAND_Y:
                        begin
                            o.expand_cleared = stretch_y & ~wd;
                            stretch_y = wd;
                        end
                        REG_MEMORY:      mem_ptrs = wd & MEMORY_WR_MASK;
                        REG_IRQ_STATUS:  irq_pend = irq_pend & ~wd[3:0];
                        REG_IRQ_MASK:    irq_en = wd[3:0];
                        REG_PRIORITY:    prio = wd;
                        REG_MULTICOLOR:  mcolor = wd;
                        REG_EXPAND_X:    stretch_x = wd;
                        REG_BORDER:      border = wd[3:0];
                        REG_SHARED_0:    shared_of[0] = wd[3:0];
                        REG_SHARED_1:    shared_of[1] = wd[3:0];
                        default:         ;
                    endcase
                end
            end
            OP_PEEK:
            begin
                // raw stored values where the peek skips the padding
                case (off)
                    REG_CONTROL_TWO: o.read_data = ctrl_b;
                    REG_MEMORY:      o.read_data = mem_ptrs;
                    REG_BORDER:      o.read_data = {4'h0, border};
                    REG_BACK_FIRST:  o.read_data = {4'h0, back_of[0]};
                    REG_SHARED_0:    o.read_data = {4'h0, shared_of[0]};
                    REG_SHARED_1:    o.read_data = {4'h0, shared_of[1]};
                    default:
                    begin
                        v = register_view(off, r.raster_line, hit);
                        o.read_data = hit ? v : UNMAPPED_PEEK;
                    end
                endcase
            end
            OP_PEN:
            begin
                // only the first strobe of a frame latches
                if (!pen_latched)
                begin
                    pen_col = r.beam_dot[8:1];
                    pen_row = r.raster_line[7:0];
                    pen_latched = 1'b1;
                    irq_pend = irq_pend | IRQ_PEN_BIT;
                end
            end
            OP_EVENT:
            begin
                spr_hits = spr_hits | r.sprite_hit_bits;
                bg_hits = bg_hits | r.background_hit_bits;
                irq_pend = irq_pend | r.irq_source_bits;
            end
            OP_FRAME:        pen_latched = 1'b0;
            default:         ;
        endcase
        o.irq_out = irq_active();
        return o;
    endfunction

    function automatic stim_row_t table_row(input logic fixed, input svrf_rsp_t want,
                                            input logic [2:0] op, input logic [5:0] off,
                                            input logic [7:0] wd, input logic [8:0] raster,
                                            input logic [8:0] dot, input logic [7:0] spr,
                                            input logic [7:0] bg, input logic [3:0] src);
        stim_row_t row;
        row.item = {op, off, wd, raster, dot, spr, bg, src};
        row.fixed = fixed;
        row.want = want;
        return row;
    endfunction

    // offer one request transaction, predict its response at acceptance
    task automatic push_request(input svrf_req_t item, input logic fixed, input svrf_rsp_t want);
        svrf_rsp_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        request <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = register_access(item);
        expected_q.push_back(fixed ? want : predicted);
    endtask

    // hold off the sender until every response has come back
    task automatic drain_pending();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_q.size() != 0);
    endtask

    // response checking and receiver stalls
    always @(posedge clk)
    begin : check_response
        svrf_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_q.size() == 0)
                flag_error($sformatf("unexpected response: data %02h irq %0b cleared %02h",
                                     response.read_data, response.irq_out,
                                     response.expand_cleared));
            else
            begin
                want = expected_q.pop_front();
                if (response.read_data !== want.read_data)
                    flag_error($sformatf("read_data: expected %02h, got %02h",
                                         want.read_data, response.read_data));
                if (response.irq_out !== want.irq_out)
                    flag_error($sformatf("irq_out: expected %0b, got %0b",
                                         want.irq_out, response.irq_out));
                if (response.expand_cleared !== want.expand_cleared)
                    flag_error($sformatf("expand_cleared: expected %02h, got %02h",
                                         want.expand_cleared, response.expand_cleared));
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        svrf_req_t item;
        int        pick;

        // shadow state after reset
        for (int i = 0; i < SPRITE_SLOTS; i++)
        begin
            pos_x_lo[i] = 8'h00;
            pos_y[i] = 8'h00;
            colour_of[i] = 4'h0;
        end
        for (int i = 0; i < 4; i++)
            back_of[i] = 4'h0;
        shared_of[0] = 4'h0;
        shared_of[1] = 4'h0;
        x_msbs = 8'h00;
        ctrl_a = 7'h00;
        ctrl_b = 8'h00;
        line_cmp = 9'h000;
        enables = 8'h00;
        stretch_y = 8'h00;
        stretch_x = 8'h00;
        mem_ptrs = 8'h00;
        irq_pend = 4'h0;
        irq_en = 4'h0;
        prio = 8'h00;
        mcolor = 8'h00;
        spr_hits = 8'h00;
        bg_hits = 8'h00;
        border = 4'h0;
        pen_col = 8'h00;
        pen_row = 8'h00;
        pen_latched = 1'b0;
        last_bus = BUS_RESET;

        // directed table: fixed rows carry their response, the rest use the predictor
        // status after reset shows only the padding
        directed_rows.push_back(table_row(1'b1, {8'h70, 1'b0, 8'h00},
            OP_READ, REG_IRQ_STATUS, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // unmapped read returns the bus byte, unmapped peek all ones
        directed_rows.push_back(table_row(1'b1, {8'h70, 1'b0, 8'h00},
            OP_READ, REG_UNMAPPED_FIRST, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'hFF, 1'b0, 8'h00},
            OP_PEEK, REG_OFFSET_TOP, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // expand-y set then fully cleared
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b0, 8'h00},
            OP_WRITE, REG_EXPAND_Y, 8'hFF, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b0, 8'hFF},
            OP_WRITE, REG_EXPAND_Y, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // all sources enabled, then every event bit
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b0, 8'h00},
            OP_WRITE, REG_IRQ_MASK, 8'h0F, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b1, 8'h00},
            OP_EVENT, 6'h00, 8'h00, 9'h000, 9'h000, 8'hFF, 8'hFF, 4'hF));
        // collision reads clear, a peek does not
        directed_rows.push_back(table_row(1'b1, {8'hFF, 1'b1, 8'h00},
            OP_READ, REG_SPRITE_HIT, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b1, 8'h00},
            OP_READ, REG_SPRITE_HIT, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'hFF, 1'b1, 8'h00},
            OP_PEEK, REG_DATA_HIT, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'hFF, 1'b1, 8'h00},
            OP_READ, REG_DATA_HIT, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // write-one-to-clear on the status
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b0, 8'h00},
            OP_WRITE, REG_IRQ_STATUS, 8'h0F, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // light pen at the far corner, then a second strobe in the same frame
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b1, 8'h00},
            OP_PEN, 6'h00, 8'h00, 9'h1FF, 9'h1FF, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b1, 8'h00},
            OP_PEN, 6'h00, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'hFF, 1'b1, 8'h00},
            OP_READ, REG_PEN_X, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b1, {8'hF8, 1'b1, 8'h00},
            OP_READ, REG_IRQ_STATUS, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // new frame re-arms the pen latch
        directed_rows.push_back(table_row(1'b1, {8'h00, 1'b1, 8'h00},
            OP_FRAME, 6'h00, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b0, '0,
            OP_PEN, 6'h00, 8'h00, 9'h100, 9'h002, 8'h00, 8'h00, 4'h0));
        // control one and raster bit 8
        directed_rows.push_back(table_row(1'b0, '0,
            OP_WRITE, REG_CONTROL_ONE, 8'hFF, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b0, '0,
            OP_READ, REG_CONTROL_ONE, 8'h00, 9'h1FF, 9'h000, 8'h00, 8'h00, 4'h0));
        // memory setup: peek shows the raw value
        directed_rows.push_back(table_row(1'b0, '0,
            OP_WRITE, REG_MEMORY, 8'hFF, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        directed_rows.push_back(table_row(1'b0, '0,
            OP_PEEK, REG_MEMORY, 8'h00, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // read-only register ignores writes
        directed_rows.push_back(table_row(1'b0, '0,
            OP_WRITE, REG_PEN_Y, 8'h55, 9'h000, 9'h000, 8'h00, 8'h00, 4'h0));
        // spare opcodes do nothing
        directed_rows.push_back(table_row(1'b0, '0,
            OP_SPARE_A, REG_ENABLE, 8'hFF, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 4'hF));
        directed_rows.push_back(table_row(1'b0, '0,
            OP_SPARE_B, REG_ENABLE, 8'hFF, 9'h1FF, 9'h1FF, 8'hFF, 8'hFF, 4'hF));

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            push_request(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
        drain_pending();

        // random traffic, one idle profile per phase
        for (int p = 0; p < 5; p++)
        begin
            send_gap_pct = phase_send_gap[p];
            recv_stall_pct = phase_recv_stall[p];
            repeat (PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 30)
                    item.opcode = OP_READ;
                else if (pick < 58)
                    item.opcode = OP_WRITE;
                else if (pick < 72)
                    item.opcode = OP_PEEK;
                else if (pick < 80)
                    item.opcode = OP_PEN;
                else if (pick < 89)
                    item.opcode = OP_EVENT;
                else if (pick < 95)
                    item.opcode = OP_FRAME;
                else
                    item.opcode = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
                // mostly mapped offsets, some in the unmapped tail
                if ($urandom_range(9) == 0)
                    item.reg_offset = 6'($urandom_range(REG_OFFSET_TOP, REG_UNMAPPED_FIRST));
                else
                    item.reg_offset = 6'($urandom_range(REG_UNMAPPED_FIRST - 1, 0));
                item.write_data = 8'($urandom);
                item.raster_line = 9'($urandom);
                item.beam_dot = 9'($urandom);
                item.sprite_hit_bits = 8'($urandom);
                item.background_hit_bits = 8'($urandom);
                item.irq_source_bits = 4'($urandom);
                push_request(item, 1'b0, '0);
            end
            drain_pending();
        end

        // let any stray response show up
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
